// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the display scan RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/mdds_pkg.sv =====
// Package for the multiplexed decimal display scanner.
// Transaction types, control struct, op codes, state enum, segment table.
`timescale 1ns / 1ps

package mdds_pkg;

    localparam int DIGIT_COUNT_DEF = 8;
    localparam int NUMBER_BITS_DEF = 32;
    localparam int VALUE_W         = 32;
    localparam int SEG_W           = 8;
    localparam int LINE_W          = 8;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [SEG_W-1:0]  SEG_BLANK  = 8'hFF;
    localparam logic [LINE_W-1:0] LINE_FIRST = 8'h80;

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [SEG_W-1:0]  segments;
        logic [LINE_W-1:0] digit_lines;
    } result_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_CONVERT
    } state_t;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] d);
        logic [SEG_W-1:0] p;
        case (d)
            4'd0:    p = 8'hC0;
            4'd1:    p = 8'hF9;
            4'd2:    p = 8'hA4;
            4'd3:    p = 8'hB0;
            4'd4:    p = 8'h99;
            4'd5:    p = 8'h92;
            4'd6:    p = 8'h82;
            4'd7:    p = 8'hF8;
            4'd8:    p = 8'h80;
            4'd9:    p = 8'h90;
            default: p = SEG_BLANK;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/mdds_bcd_cell.sv =====
// One BCD digit cell of the shift-and-add-3 converter row.
// Depends on mdds_pkg.
`timescale 1ns / 1ps

module mdds_bcd_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  mdds_pkg::cell_ctrl_t ctrl,
    input  logic                bit_in,
    output logic                bit_out,
    output logic [3:0]          digit
);
    import mdds_pkg::*;

    `include "assert_macros.svh"

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    always_comb
    begin
        adj     = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        bit_out = adj[3];
        if (ctrl.load)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.shift)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

    `ASSERT_IMPLIES(a_digit_bcd, clk, rst_n, 1'b1, digit_reg <= 4'd9)

endmodule

// ===== rtl/mdds_bcd_chain.sv =====
// Row of BCD cells fed MSB first from the held number.
// Depends on mdds_pkg and mdds_bcd_cell.
`timescale 1ns / 1ps

module mdds_bcd_chain #(
    parameter int DIGIT_COUNT = mdds_pkg::DIGIT_COUNT_DEF,
    parameter int NUMBER_BITS = mdds_pkg::NUMBER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mdds_pkg::cell_ctrl_t            ctrl,
    input  logic [mdds_pkg::VALUE_W-1:0]    value,
    output logic [DIGIT_COUNT-1:0][3:0]     digits
);
    import mdds_pkg::*;

    localparam int WIDE_W = (NUMBER_BITS > VALUE_W) ? NUMBER_BITS : VALUE_W;

    logic [NUMBER_BITS-1:0] number_reg;
    logic [NUMBER_BITS-1:0] number_next;
    logic [WIDE_W-1:0]      value_wide;
    logic [DIGIT_COUNT:0]   carry;

    assign value_wide = WIDE_W'(value);
    assign carry[0]   = number_reg[NUMBER_BITS-1];

    // top carry recirculates into the lsb; within one pass it is never shifted back out of the msb
    always_comb
    begin
        if (ctrl.load)
        begin
            number_next = value_wide[NUMBER_BITS-1:0];
        end
        else if (ctrl.shift)
        begin
            number_next = {number_reg[NUMBER_BITS-2:0], carry[DIGIT_COUNT]};
        end
        else
        begin
            number_next = number_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        number_reg <= number_next;
    end

    for (genvar g = 0; g < DIGIT_COUNT; g++)
    begin : g_cell
        mdds_bcd_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .bit_in  (carry[g]),
            .bit_out (carry[g+1]),
            .digit   (digits[g])
        );
    end

endmodule

// ===== rtl/multiplexed_decimal_display_scan.sv =====
// A scan tick transaction puts its result in the output register in the following cycle.
// One scan tick per cycle while idle and the output is not stalled; during a load the input
// stalls and the number shifts one step per cycle through the row of BCD digit cells.
// A load gives no result. Reset (rst_n low, async) clears the digits, scan index,
// phase, held digit lines (all low) and the output valid.
`timescale 1ns / 1ps

module multiplexed_decimal_display_scan #(
    parameter int DIGIT_COUNT = mdds_pkg::DIGIT_COUNT_DEF,
    parameter int NUMBER_BITS = mdds_pkg::NUMBER_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mdds_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mdds_pkg::result_t result
);
    import mdds_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int CNT_W = $clog2(NUMBER_BITS);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   bit_cnt_reg;
    logic [CNT_W-1:0]   bit_cnt_next;
    logic [IDX_W-1:0]   scan_index_reg;
    logic [IDX_W-1:0]   scan_index_next;
    logic               bright_phase_reg;
    logic               bright_phase_next;
    logic [LINE_W-1:0]  held_lines_reg;
    logic [LINE_W-1:0]  held_lines_next;
    logic               result_valid_reg;
    logic               result_valid_next;
    result_t            result_reg;
    result_t            result_next;

    cell_ctrl_t               ctrl;
    logic                     conv_shift;
    logic [DIGIT_COUNT-1:0][3:0] digits;
    logic                     item_take;
    logic                     tick_take;
    logic                     load_take;
    logic                     phase_now;
    logic [2:0]               line_sel;
    logic [LINE_W-1:0]        line_pattern;

    mdds_bcd_chain #(
        .DIGIT_COUNT (DIGIT_COUNT),
        .NUMBER_BITS (NUMBER_BITS)
    ) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .value  (item.value),
        .digits (digits)
    );

    // next state
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load_take)
                begin
                    state_next   = ST_CONVERT;
                    bit_cnt_next = '0;
                end
            end
            ST_CONVERT:
            begin
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == CNT_W'(NUMBER_BITS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item_stall = 1'b1;
        conv_shift = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = result_valid_reg && result_stall;
            end
            ST_CONVERT:
            begin
                conv_shift = 1'b1;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    assign item_take = item_valid && !item_stall;
    assign tick_take = item_take && (item.op == OP_TICK);
    assign load_take = item_take && (item.op == OP_LOAD);
    assign ctrl      = {load_take, conv_shift};

    // scan datapath
    always_comb
    begin
        phase_now    = (scan_index_reg == '0) ? !bright_phase_reg : bright_phase_reg;
        line_sel     = 3'(scan_index_reg);
        line_pattern = ~(LINE_FIRST >> line_sel);

        scan_index_next   = scan_index_reg;
        bright_phase_next = bright_phase_reg;
        held_lines_next   = held_lines_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (tick_take)
        begin
            bright_phase_next = phase_now;
            if (phase_now)
            begin
                held_lines_next      = line_pattern;
                result_next.segments = seg_pattern(digits[scan_index_reg]);
            end
            else
            begin
                result_next.segments = SEG_BLANK;
            end
            result_next.digit_lines = phase_now ? line_pattern : held_lines_reg;
            result_valid_next       = 1'b1;
            scan_index_next = (scan_index_reg == IDX_W'(DIGIT_COUNT - 1)) ?
                              '0 : scan_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            bit_cnt_reg      <= '0;
            scan_index_reg   <= '0;
            bright_phase_reg <= 1'b0;
            held_lines_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            bit_cnt_reg      <= bit_cnt_next;
            scan_index_reg   <= scan_index_next;
            bright_phase_reg <= bright_phase_next;
            held_lines_reg   <= held_lines_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_IMPLIES(a_convert_stalls, clk, rst_n, state_reg == ST_CONVERT, item_stall)
    `ASSERT_NEXT(a_tick_gives_result, clk, rst_n, tick_take, result_valid_reg)
    `ASSERT_NEXT(a_load_starts_convert, clk, rst_n, load_take,
                 state_reg == ST_CONVERT && bit_cnt_reg == '0)
    `ASSERT_IMPLIES(a_index_in_range, clk, rst_n, 1'b1,
                    scan_index_reg <= IDX_W'(DIGIT_COUNT - 1))
    `ASSERT_NEXT(a_load_no_result, clk, rst_n, load_take && !result_valid_reg,
                 !result_valid_reg)

endmodule

// ===== tb/sv/mdds_scan_checker.sv =====
`timescale 1ns / 1ps
// Checker for the multiplexed decimal display scanner: watches both channels,
// predicts each scan frame from the load and tick transactions, and compares.
// Depends on mdds_pkg for the transaction types, op codes and display constants.

module mdds_scan_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  mdds_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  mdds_pkg::result_t result,
    output int                mismatches,
    output int                outstanding
);
    import mdds_pkg::*;

    logic [VALUE_W-1:0] shown = '0;
    logic [2:0]         scan_pos = '0;
    logic               bright = 1'b0;
    logic [LINE_W-1:0]  held_lines = '0;
    result_t            frames_due[$];
    int                 fail_tally = 0;
    int                 due_count = 0;

    assign mismatches  = fail_tally;
    assign outstanding = due_count;

    function automatic logic [3:0] decimal_at(input logic [VALUE_W-1:0] n, input int pos);
        logic [VALUE_W-1:0] r;
        r = n;
        for (int i = 0; i < pos; i++)
        begin
            r = r / 10;
        end
        return 4'(r % 10);
    endfunction

    function automatic logic [SEG_W-1:0] glyph_of(input logic [3:0] d);
        logic [SEG_W-1:0] g;
        case (d)
            4'd0:    g = 8'hC0;
            4'd1:    g = 8'hF9;
            4'd2:    g = 8'hA4;
            4'd3:    g = 8'hB0;
            4'd4:    g = 8'h99;
            4'd5:    g = 8'h92;
            4'd6:    g = 8'h82;
            4'd7:    g = 8'hF8;
            4'd8:    g = 8'h80;
            default: g = 8'h90;
        endcase
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            shown = '0;
            scan_pos = '0;
            bright = 1'b0;
            held_lines = '0;
            frames_due.delete();
            due_count = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("unexpected frame: segments %h digit_lines %h",
                           result.segments, result.digit_lines);
                    fail_tally++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (result.segments !== want.segments)
                    begin
                        $error("segments: expected %h, got %h", want.segments, result.segments);
                        fail_tally++;
                    end
                    if (result.digit_lines !== want.digit_lines)
                    begin
                        $error("digit_lines: expected %h, got %h",
                               want.digit_lines, result.digit_lines);
                        fail_tally++;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                if (item.op == OP_LOAD)
                begin
                    shown = item.value;
                end
                else
                begin
                    if (scan_pos == 3'd0)
                        bright = ~bright;
                    if (bright)
                    begin
                        held_lines = ~(LINE_FIRST >> scan_pos);
                        want.segments = glyph_of(decimal_at(shown, int'(scan_pos)));
                    end
                    else
                    begin
                        want.segments = SEG_BLANK;
                    end
                    want.digit_lines = held_lines;
                    frames_due.push_back(want);
                    scan_pos = scan_pos + 3'd1;
                end
            end
            due_count = frames_due.size();
        end
    end

endmodule

// ===== tb/sv/multiplexed_decimal_display_scan_test.sv =====
`timescale 1ns / 1ps
// Top of the display scanner testbench: clock, reset, load/tick stimulus with random
// gaps and output stalls, and the verdict. Depends on mdds_pkg, the RTL and mdds_scan_checker.

module multiplexed_decimal_display_scan_test;

    import mdds_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 900;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    int      mismatches;
    int      outstanding;
    int      cycles = 0;
    bit      quiet = 1'b0;

    multiplexed_decimal_display_scan dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    mdds_scan_checker board (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("multiplexed_decimal_display_scan: mismatch");
            $finish;
        end
    end

    task automatic send(input logic op, input logic [VALUE_W-1:0] value);
        int    gap;
        item_t next;
        gap = quiet ? 0 : $urandom_range(0, 4);
        next.op = op;
        next.value = value;
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item <= next;
        do @(posedge clk); while (!(item_valid && !item_stall));
    endtask

    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_number();
        logic [VALUE_W-1:0] n;
        case ($urandom_range(0, 7))
            0:       n = $urandom_range(0, 999);
            1:       n = 32'd99999990 + $urandom_range(0, 20);
            2:       n = 32'hFFFF_FFFF - $urandom_range(0, 3);
            3:       n = $urandom_range(0, 99999999);
            default: n = $urandom();
        endcase
        return n;
    endfunction

    // output side: random stall before each transaction
    initial
    begin
        int hold;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 4);
            repeat (hold)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
            end
            @(negedge clk);
            result_stall <= 1'b0;
            do @(posedge clk); while (!(result_valid && !result_stall));
        end
    end

    initial
    begin
        item_valid = 1'b0;
        item = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full-scale value, then the 10^8 wrap during a blank frame, then the 8-digit maximum
        send(OP_LOAD, 32'hFFFF_FFFF);
        repeat (8) send(OP_TICK, '0);
        send(OP_LOAD, 32'd100000000);
        repeat (8) send(OP_TICK, 32'hFFFF_FFFF);
        send(OP_LOAD, 32'd99999999);
        repeat (4) send(OP_TICK, '0);
        drain();
        send(OP_LOAD, '0);
        repeat (2) send(OP_TICK, $urandom());
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 60 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (i % 150 == 149)
                drain();
            if ($urandom_range(0, 99) < 15)
                send(OP_LOAD, pick_number());
            else
                send(OP_TICK, $urandom());
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("multiplexed_decimal_display_scan: match");
        else
            $display("multiplexed_decimal_display_scan: mismatch");
        $finish;
    end

endmodule
